// ===== design/owik_pkg.sv =====
// ----------------------------------------------------------------------------
// owik_pkg
// Shared types and constants for the omni wheel inverse kinematics unit.
// ----------------------------------------------------------------------------
package owik_pkg;

    localparam int LANES        = 3;
    localparam int SERIES_TERMS = 12;
    localparam int FRONT_STAGES = 2;
    localparam int CELL_STAGES  = 3;
    localparam int WHEEL_STAGES = 5;

    // 2*pi in Q30 and one in Q30
    localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

    // register index, taken from paddr[2]
    localparam logic REG_HALF_DIAMETER    = 1'b0;
    localparam logic REG_COUNTS_PER_METER = 1'b1;

    localparam logic [15:0] HALF_DIAMETER_RST    = 16'd4915;
    localparam logic [23:0] COUNTS_PER_METER_RST = 24'd1053068;

    // quadrants with negative cosine
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    localparam logic [23:0] OUT_MAX     = 24'h7F_FFFF;
    localparam logic [23:0] OUT_MIN     = 24'h80_0000;
    localparam logic [24:0] OUT_MIN_MAG = 25'h080_0000;

    // one wheel lane as it moves along the series cells
    typedef struct packed {
        logic               odd;
        logic [1:0]         quad;
        logic [31:0]        x2;
        logic [30:0]        t;
        logic signed [33:0] acc;
    } t_series;

endpackage

// ===== design/owik_front.sv =====
// ----------------------------------------------------------------------------
// owik_front
// Phase to radians and square, seeds the series for one wheel lane.
// ----------------------------------------------------------------------------
module owik_front #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_phase,
    output owik_pkg::t_series     o_ser
);

    localparam int PW = ANGLE_BITS + 31;

    logic [ANGLE_BITS-3:0] w_rem;
    logic [PW-1:0]         w_xprod;
    logic [61:0]           w_x2prod;
    logic [30:0]           w_t0;
    owik_pkg::t_series     w_ser;

    logic [30:0]       r1_x;
    logic [1:0]        r1_quad;
    owik_pkg::t_series r2_ser;

    assign w_rem   = i_phase[ANGLE_BITS-3:0];
    assign w_xprod = PW'(w_rem) * PW'(owik_pkg::TWO_PI_Q30);

    assign w_x2prod = 62'(r1_x) * 62'(r1_x);
    assign w_t0     = r1_quad[0] ? r1_x : owik_pkg::ONE_Q30;

    always_comb begin
        w_ser.odd  = r1_quad[0];
        w_ser.quad = r1_quad;
        w_ser.x2   = w_x2prod[61:30];
        w_ser.t    = w_t0;
        w_ser.acc  = $signed({3'b000, w_t0});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x    <= w_xprod[ANGLE_BITS+30:ANGLE_BITS];
            r1_quad <= i_phase[ANGLE_BITS-1:ANGLE_BITS-2];
            r2_ser  <= w_ser;
        end
    end

    assign o_ser = r2_ser;

endmodule

// ===== design/owik_cell.sv =====
// ----------------------------------------------------------------------------
// owik_cell
// One Taylor term: t = ((t * x^2) >> 30) / (k * (k + 1)), folded into acc.
// ----------------------------------------------------------------------------
module owik_cell #(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  owik_pkg::t_series i_ser,
    output owik_pkg::t_series o_ser
);

    localparam int unsigned K_EVEN = 2 * IDX + 1;
    localparam int unsigned D_EVEN = K_EVEN * (K_EVEN + 1);
    localparam int unsigned D_ODD  = (K_EVEN + 1) * (K_EVEN + 2);
    localparam logic [32:0] M_EVEN = 33'((64'd1 << 33) / D_EVEN);
    localparam logic [32:0] M_ODD  = 33'((64'd1 << 33) / D_ODD);
    localparam logic [9:0]  DIV_EVEN = 10'(D_EVEN);
    localparam logic [9:0]  DIV_ODD  = 10'(D_ODD);
    localparam bit          SUB      = (IDX % 2) == 0;

    logic [62:0]        w_prod;
    logic [32:0]        w_recip;
    logic [65:0]        w_qprod;
    logic [9:0]         w_div;
    logic [42:0]        w_qd;
    logic [32:0]        w_left;
    logic [32:0]        w_q;
    logic signed [33:0] w_tq;
    owik_pkg::t_series  w_out;

    logic [32:0]       r1_p;
    owik_pkg::t_series r1_ser;
    logic [32:0]       r2_p;
    logic [32:0]       r2_qe;
    owik_pkg::t_series r2_ser;
    owik_pkg::t_series r3_ser;

    assign w_prod = 63'(i_ser.t) * 63'(i_ser.x2);

    // reciprocal estimate, low by at most one
    assign w_recip = r1_ser.odd ? M_ODD : M_EVEN;
    assign w_qprod = 66'(r1_p) * 66'(w_recip);

    assign w_div  = r2_ser.odd ? DIV_ODD : DIV_EVEN;
    assign w_qd   = 43'(r2_qe) * 43'(w_div);
    assign w_left = r2_p - w_qd[32:0];
    assign w_q    = r2_qe + 33'(w_left >= 33'(w_div));
    assign w_tq   = $signed({3'b000, w_q[30:0]});

    always_comb begin
        w_out     = r2_ser;
        w_out.t   = w_q[30:0];
        w_out.acc = SUB ? (r2_ser.acc - w_tq) : (r2_ser.acc + w_tq);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p   <= w_prod[62:30];
            r1_ser <= i_ser;
            r2_p   <= r1_p;
            r2_qe  <= w_qprod[65:33];
            r2_ser <= r1_ser;
            r3_ser <= w_out;
        end
    end

    assign o_ser = r3_ser;

endmodule

// ===== design/owik_wheel.sv =====
// ----------------------------------------------------------------------------
// owik_wheel
// Rounds the cosine, forms wheel speed and scales it to saturated counts.
// ----------------------------------------------------------------------------
module owik_wheel #(
    parameter int COS_FRAC_BITS = 15
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  owik_pkg::t_series  i_ser,
    input  logic signed [15:0] i_speed,
    input  logic signed [15:0] i_omega,
    input  logic [15:0]        i_half_diameter,
    input  logic [23:0]        i_counts_per_meter,
    output logic [23:0]        o_count,
    output logic               o_sat
);

    localparam int CW   = COS_FRAC_BITS + 5;
    localparam int LW   = CW + 16;
    localparam int VW   = COS_FRAC_BITS + 34;
    localparam int MW   = COS_FRAC_BITS + 33;
    localparam int HPW  = MW - 32 + 24;
    localparam int MIDW = HPW + 1;
    localparam logic [33:0] RND = 34'(64'd1 << (29 - COS_FRAC_BITS));

    logic [32:0]             w_u;
    logic [33:0]             w_sum;
    logic [COS_FRAC_BITS+3:0] w_c;
    logic signed [CW-1:0]    w_cpos;
    logic signed [CW-1:0]    w_cos;
    logic signed [LW-1:0]    w_lin;
    logic signed [32:0]      w_turn;
    logic signed [VW-1:0]    w_v;
    logic signed [VW-1:0]    w_abs;
    logic [MIDW-1:0]         w_mid;
    logic [23:0]             w_whole;
    logic                    w_rem;
    logic [24:0]             w_wn;
    logic [24:0]             w_negc;
    logic [23:0]             w_count;
    logic                    w_sat;

    logic signed [CW-1:0] r0_cos;
    logic signed [15:0]   r0_speed;
    logic signed [15:0]   r0_omega;
    logic signed [LW-1:0] r1_lin;
    logic signed [32:0]   r1_turn;
    logic                 r2_neg;
    logic [MW-1:0]        r2_mag;
    logic                 r3_neg;
    logic [55:0]          r3_lo;
    logic [HPW-1:0]       r3_hi;
    logic [23:0]          r4_count;
    logic                 r4_sat;

    assign w_u    = i_ser.acc[33] ? 33'd0 : i_ser.acc[32:0];
    assign w_sum  = 34'(w_u) + RND;
    assign w_c    = w_sum[33:30-COS_FRAC_BITS];
    assign w_cpos = $signed(CW'(w_c));
    assign w_cos  = (i_ser.quad == owik_pkg::QUAD_II || i_ser.quad == owik_pkg::QUAD_III)
                    ? -w_cpos : w_cpos;

    assign w_lin  = LW'(r0_speed) * LW'(r0_cos);
    assign w_turn = 33'(r0_omega) * $signed({17'd0, i_half_diameter});

    assign w_v   = (VW'(r1_lin) <<< 14) - (VW'(r1_turn) <<< COS_FRAC_BITS);
    assign w_abs = w_v[VW-1] ? -w_v : w_v;

    assign w_mid   = MIDW'(r3_hi) + MIDW'(r3_lo[55:32]);
    assign w_whole = w_mid[MIDW-1:COS_FRAC_BITS+2];
    assign w_rem   = (|r3_lo[31:0]) | (|w_mid[COS_FRAC_BITS+1:0]);
    assign w_wn    = 25'(w_whole) + 25'(w_rem);
    assign w_negc  = 25'd0 - w_wn;

    always_comb begin
        w_sat   = 1'b0;
        w_count = w_whole;
        if (r3_neg) begin
            if (w_wn > owik_pkg::OUT_MIN_MAG) begin
                w_sat   = 1'b1;
                w_count = owik_pkg::OUT_MIN;
            end else begin
                w_count = w_negc[23:0];
            end
        end else if (w_whole > owik_pkg::OUT_MAX) begin
            w_sat   = 1'b1;
            w_count = owik_pkg::OUT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_cos   <= w_cos;
            r0_speed <= i_speed;
            r0_omega <= i_omega;
            r1_lin   <= w_lin;
            r1_turn  <= w_turn;
            r2_neg   <= w_v[VW-1];
            r2_mag   <= w_abs[MW-1:0];
            r3_neg   <= r2_neg;
            r3_lo    <= 56'(r2_mag[31:0]) * 56'(i_counts_per_meter);
            r3_hi    <= HPW'(r2_mag[MW-1:32]) * HPW'(i_counts_per_meter);
            r4_count <= w_count;
            r4_sat   <= w_sat;
        end
    end

    assign o_count = r4_count;
    assign o_sat   = r4_sat;

endmodule

// ===== design/omni_wheel_inverse_kinematics_unit.sv =====
// ----------------------------------------------------------------------------
// omni_wheel_inverse_kinematics_unit
// Three wheel omni drive: motion command to per-wheel encoder count rates.
// ----------------------------------------------------------------------------
// One command is taken every clock cycle unless the input stalls, and each gives
// one result; its delay is set by the cosine path of each wheel lane,
// a row of twelve series cells of three register stages each, plus input,
// front and scaling stages and the output register. A two-entry output buffer
// decouples the ready signals: the input keeps flowing while one result waits
// on the output, and stalls once a second result is held until the first drains.
// Registers: half_diameter at byte address 0, counts_per_meter at 4; the
// address decode looks at paddr[2] only.
module omni_wheel_inverse_kinematics_unit #(
    parameter int ANGLE_BITS    = 16,
    parameter int COS_FRAC_BITS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // linear_speed[15:0], heading[31:16], turn_rate[47:32]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // wheel_one_counts[23:0], wheel_two_counts[47:24], wheel_three_counts[71:48],
    // saturated[72], zero[79:73]
    output logic [79:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LANES = owik_pkg::LANES;
    localparam int TERMS = owik_pkg::SERIES_TERMS;
    localparam int DLY   = owik_pkg::FRONT_STAGES + owik_pkg::CELL_STAGES * TERMS;
    localparam int VLD_N = 1 + DLY + owik_pkg::WHEEL_STAGES;
    localparam logic [ANGLE_BITS-1:0] THIRD =
        ANGLE_BITS'(((64'd1 << ANGLE_BITS) + 64'd1) / 64'd3);

    logic                     w_en;
    logic [ANGLE_BITS+15:0]   w_head_ext;
    logic [ANGLE_BITS-1:0]    w_phase;
    logic                     w_take;
    logic [72:0]              w_result;
    owik_pkg::t_series        w_ser [LANES][TERMS+1];
    logic [23:0]              w_count [LANES];
    logic                     w_sat [LANES];

    logic [15:0]              r_half_diameter;
    logic [23:0]              r_counts_per_meter;
    logic [ANGLE_BITS-1:0]    r_phase [LANES];
    logic signed [15:0]       r_s0_speed;
    logic signed [15:0]       r_s0_omega;
    logic signed [15:0]       r_side_speed [DLY];
    logic signed [15:0]       r_side_omega [DLY];
    logic [VLD_N-1:0]         r_vld;
    logic                     r_out_valid;
    logic                     r_skid_valid;
    logic [72:0]              r_out_data;
    logic [72:0]              r_skid_data;
    logic                     n_out_valid;
    logic                     n_skid_valid;
    logic [72:0]              n_out_data;
    logic [72:0]              n_skid_data;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_diameter    <= owik_pkg::HALF_DIAMETER_RST;
            r_counts_per_meter <= owik_pkg::COUNTS_PER_METER_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                owik_pkg::REG_HALF_DIAMETER:    r_half_diameter    <= pwdata[15:0];
                owik_pkg::REG_COUNTS_PER_METER: r_counts_per_meter <= pwdata[23:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            owik_pkg::REG_HALF_DIAMETER:    prdata = {16'd0, r_half_diameter};
            owik_pkg::REG_COUNTS_PER_METER: prdata = {8'd0, r_counts_per_meter};
        endcase
    end

    // input stage: wheel phases
    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;
    assign w_head_ext    = {s_axis_tdata[31:16], {ANGLE_BITS{1'b0}}};
    assign w_phase       = w_head_ext[ANGLE_BITS+15:16];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_phase[0] <= w_phase;
            r_phase[1] <= w_phase + THIRD;
            r_phase[2] <= w_phase - THIRD;
            r_s0_speed <= $signed(s_axis_tdata[15:0]);
            r_s0_omega <= $signed(s_axis_tdata[47:32]);
            r_side_speed[0] <= r_s0_speed;
            r_side_omega[0] <= r_s0_omega;
            for (int j = 1; j < DLY; j++) begin
                r_side_speed[j] <= r_side_speed[j-1];
                r_side_omega[j] <= r_side_omega[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[VLD_N-2:0], s_axis_tvalid};
        end
    end

    // wheel lanes
    for (genvar g_lane = 0; g_lane < LANES; g_lane++) begin : g_lanes
        owik_front #(
            .ANGLE_BITS (ANGLE_BITS)
        ) u_front (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_phase (r_phase[g_lane]),
            .o_ser   (w_ser[g_lane][0])
        );

        for (genvar g_term = 0; g_term < TERMS; g_term++) begin : g_cells
            owik_cell #(
                .IDX (g_term)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_ser (w_ser[g_lane][g_term]),
                .o_ser (w_ser[g_lane][g_term+1])
            );
        end

        owik_wheel #(
            .COS_FRAC_BITS (COS_FRAC_BITS)
        ) u_wheel (
            .i_clk              (i_clk),
            .i_en               (w_en),
            .i_ser              (w_ser[g_lane][TERMS]),
            .i_speed            (r_side_speed[DLY-1]),
            .i_omega            (r_side_omega[DLY-1]),
            .i_half_diameter    (r_half_diameter),
            .i_counts_per_meter (r_counts_per_meter),
            .o_count            (w_count[g_lane]),
            .o_sat              (w_sat[g_lane])
        );
    end

    assign w_result = {w_sat[0] | w_sat[1] | w_sat[2], w_count[2], w_count[1], w_count[0]};

    // output register with skid entry
    assign w_take = r_out_valid && m_axis_tready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_skid_data  = r_skid_data;
        if (w_en && r_vld[VLD_N-1]) begin
            if (!r_out_valid || w_take) begin
                n_out_valid = 1'b1;
                n_out_data  = w_result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = w_result;
            end
        end else if (w_take) begin
            if (r_skid_valid) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_data};

endmodule
